FILE: src/stw_pkg.sv
// ----------------------------------------------------------------------------
// stw_pkg: shared types and constants of the SIMD twister generator
// Pool geometry, register reset values, register indexes and FSM states.
// ----------------------------------------------------------------------------
package stw_pkg;

  localparam int STATE_ENTRIES = 156;
  localparam int LANES         = 4;
  localparam int POOL_WORDS    = STATE_ENTRIES * LANES;
  localparam int ENTRY_AW      = $clog2(STATE_ENTRIES);
  localparam int WORD_AW       = $clog2(POOL_WORDS + 1);

  localparam logic [31:0] INIT_MULT = 32'd1812433253;

  localparam logic [ENTRY_AW-1:0] LAST_ENTRY = ENTRY_AW'(STATE_ENTRIES - 1);
  localparam logic [WORD_AW-1:0]  LAST_WORD  = WORD_AW'(POOL_WORDS - 1);
  localparam logic [WORD_AW-1:0]  WORDS_END  = WORD_AW'(POOL_WORDS);

  // register reset values
  localparam logic [7:0]  LAG_RESET   = 8'd65;
  localparam logic [4:0]  LSH_RESET   = 5'd3;
  localparam logic [4:0]  RSH_RESET   = 5'd29;
  localparam logic [31:0] MASK0_RESET = 32'hffeffafd;
  localparam logic [31:0] MASK1_RESET = 32'hdfedf8ff;
  localparam logic [31:0] MASK2_RESET = 32'hff6ff37d;
  localparam logic [31:0] MASK3_RESET = 32'hdf5d0fbb;

  // register indexes
  localparam logic [2:0] REG_LAG   = 3'd0;
  localparam logic [2:0] REG_LSH   = 3'd1;
  localparam logic [2:0] REG_RSH   = 3'd2;
  localparam logic [2:0] REG_MASK0 = 3'd3;
  localparam logic [2:0] REG_MASK1 = 3'd4;
  localparam logic [2:0] REG_MASK2 = 3'd5;
  localparam logic [2:0] REG_MASK3 = 3'd6;

  // input commands
  localparam logic CMD_NEXT = 1'b0;
  localparam logic CMD_SEED = 1'b1;

  typedef logic [LANES-1:0][31:0] entry_t;

  typedef struct packed {
    logic [7:0]             lag_distance;
    logic [4:0]             left_shift;
    logic [4:0]             right_shift;
    logic [LANES-1:0][31:0] mask;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_REF_START,
    ST_REF_PREV,
    ST_REF_RD,
    ST_REF_WR,
    ST_NEXT_RD,
    ST_NEXT_OUT
  } state_t;

endpackage

FILE: src/stw_pool_ram.sv
// ----------------------------------------------------------------------------
// stw_pool_ram: pool memory
// Two registered read ports, one write port.
// ----------------------------------------------------------------------------
module stw_pool_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 156,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rd_a_en,
  input  logic [AW-1:0]    rd_a_addr,
  output logic [WIDTH-1:0] rd_a_data,
  input  logic             rd_b_en,
  input  logic [AW-1:0]    rd_b_addr,
  output logic [WIDTH-1:0] rd_b_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_a_en) begin
      rd_a_data <= mem[rd_a_addr];
    end
    if (rd_b_en) begin
      rd_b_data <= mem[rd_b_addr];
    end
  end

endmodule

FILE: src/stw_mix.sv
// ----------------------------------------------------------------------------
// stw_mix: one refill step
// New entry from the old entry, the lag entry and the previous new entry.
// ----------------------------------------------------------------------------
module stw_mix (
  input  stw_pkg::cfg_t   cfg,
  input  stw_pkg::entry_t old_entry,
  input  stw_pkg::entry_t lag_entry,
  input  stw_pkg::entry_t prev_entry,
  output stw_pkg::entry_t fresh
);

  always_comb begin
    for (int k = 0; k < stw_pkg::LANES; k++) begin
      // lane k takes old lane k+1, wrapping
      fresh[k] = old_entry[(k + 1) % stw_pkg::LANES]
               ^ (lag_entry[k] << cfg.left_shift)
               ^ (prev_entry[k] & cfg.mask[k])
               ^ (prev_entry[k] >> cfg.right_shift);
    end
  end

endmodule

FILE: src/simd_twister_rng_128.sv
// ----------------------------------------------------------------------------
// simd_twister_rng_128: twister-style random word generator, 156 x 128 pool
// Next request: word read, then registered once the result slot is free; new
// requests stall meanwhile. A spent pool is refilled first: prev is the old
// last entry, then per entry read old and lag entries, then mix and write back.
// Seed request: one word per cycle through the seed multiplier.
// Reset: sync, active high; pool reads as zero via per-entry valid bits,
// read position zero, registers at their default values.
// ----------------------------------------------------------------------------
module simd_twister_rng_128 (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [31:0] seed_value,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] random_word,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int AW = stw_pkg::ENTRY_AW;
  localparam int WW = stw_pkg::WORD_AW;

  stw_pkg::state_t state, state_next;
  stw_pkg::cfg_t   cfg;

  // read position into the pool words; POOL_WORDS means spent
  logic [WW-1:0] rd_pos;
  // seed word counter and running word
  logic [WW-1:0] seed_idx;
  logic [31:0]   seed_word;
  logic [31:0]   seed_first;
  logic [2:0][31:0] seed_buf;
  // refill entry counter and previous new entry
  logic [AW-1:0]   ent;
  stw_pkg::entry_t prev;
  logic [1:0]      lane_sel;

  // entries written since reset; others read as zero
  logic [stw_pkg::STATE_ENTRIES-1:0] valid;
  logic va, vb;

  // RAM ports
  logic            rd_a_en, rd_b_en, wr_en;
  logic [AW-1:0]   rd_a_addr, rd_b_addr, wr_addr;
  stw_pkg::entry_t rd_a_data, rd_b_data, wr_data;
  stw_pkg::entry_t data_a, data_b, fresh;

  // seed recursion and lag index
  logic [31:0]   seed_cur;
  logic [AW:0]   lag_sum;
  logic [AW-1:0] lag_idx;

  logic accept_in, out_take;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != stw_pkg::ST_IDLE);
  assign accept_in = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;

  assign data_a = va ? rd_a_data : '0;
  assign data_b = vb ? rd_b_data : '0;

  // w[i] = M * (w[i-1] ^ (w[i-1] >> 30)) + i
  always_comb begin
    if (seed_idx == '0) begin
      seed_cur = seed_first;
    end else begin
      seed_cur = 32'(stw_pkg::INIT_MULT * (seed_word ^ (seed_word >> 30)))
               + 32'(seed_idx);
    end
  end

  // (ent + lag) mod STATE_ENTRIES, lag up to 255 needs two folds
  always_comb begin
    lag_sum = (AW + 1)'(ent) + (AW + 1)'(cfg.lag_distance);
    if (lag_sum >= (AW + 1)'(2 * stw_pkg::STATE_ENTRIES)) begin
      lag_idx = AW'(lag_sum - (AW + 1)'(2 * stw_pkg::STATE_ENTRIES));
    end else if (lag_sum >= (AW + 1)'(stw_pkg::STATE_ENTRIES)) begin
      lag_idx = AW'(lag_sum - (AW + 1)'(stw_pkg::STATE_ENTRIES));
    end else begin
      lag_idx = AW'(lag_sum);
    end
  end

  stw_mix u_mix (
    .cfg        (cfg),
    .old_entry  (data_a),
    .lag_entry  (data_b),
    .prev_entry (prev),
    .fresh      (fresh)
  );

  stw_pool_ram #(
    .WIDTH ($bits(stw_pkg::entry_t)),
    .DEPTH (stw_pkg::STATE_ENTRIES)
  ) u_ram (
    .clk       (clk),
    .rd_a_en   (rd_a_en),
    .rd_a_addr (rd_a_addr),
    .rd_a_data (rd_a_data),
    .rd_b_en   (rd_b_en),
    .rd_b_addr (rd_b_addr),
    .rd_b_data (rd_b_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  // next state and memory controls
  always_comb begin
    state_next = state;
    rd_a_en    = 1'b0;
    rd_a_addr  = ent;
    rd_b_en    = 1'b0;
    rd_b_addr  = lag_idx;
    wr_en      = 1'b0;
    wr_addr    = ent;
    wr_data    = fresh;
    unique case (state)
      stw_pkg::ST_IDLE: begin
        if (accept_in) begin
          if (command == stw_pkg::CMD_SEED) begin
            state_next = stw_pkg::ST_SEED;
          end else if (rd_pos >= stw_pkg::WORDS_END) begin
            state_next = stw_pkg::ST_REF_START;
          end else begin
            state_next = stw_pkg::ST_NEXT_RD;
          end
        end
      end
      stw_pkg::ST_SEED: begin
        // write a full entry once lane 3 is known
        wr_en   = (seed_idx[1:0] == 2'd3);
        wr_addr = seed_idx[WW-1:2];
        wr_data = {seed_cur, seed_buf[2], seed_buf[1], seed_buf[0]};
        if (seed_idx == stw_pkg::LAST_WORD) begin
          state_next = stw_pkg::ST_IDLE;
        end
      end
      stw_pkg::ST_REF_START: begin
        // first prev is the old last entry
        rd_a_en    = 1'b1;
        rd_a_addr  = stw_pkg::LAST_ENTRY;
        state_next = stw_pkg::ST_REF_PREV;
      end
      stw_pkg::ST_REF_PREV: begin
        state_next = stw_pkg::ST_REF_RD;
      end
      stw_pkg::ST_REF_RD: begin
        rd_a_en    = 1'b1;
        rd_b_en    = 1'b1;
        state_next = stw_pkg::ST_REF_WR;
      end
      stw_pkg::ST_REF_WR: begin
        // write lands before the next read, so a lag on a new entry sees it
        wr_en = 1'b1;
        if (ent == stw_pkg::LAST_ENTRY) begin
          state_next = stw_pkg::ST_NEXT_RD;
        end else begin
          state_next = stw_pkg::ST_REF_RD;
        end
      end
      stw_pkg::ST_NEXT_RD: begin
        rd_a_en    = 1'b1;
        rd_a_addr  = rd_pos[WW-1:2];
        state_next = stw_pkg::ST_NEXT_OUT;
      end
      stw_pkg::ST_NEXT_OUT: begin
        // wait for a free output slot; read data holds meanwhile
        if (!out_valid || !out_stall) begin
          state_next = stw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = stw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lag_distance <= stw_pkg::LAG_RESET;
      cfg.left_shift   <= stw_pkg::LSH_RESET;
      cfg.right_shift  <= stw_pkg::RSH_RESET;
      cfg.mask[0]      <= stw_pkg::MASK0_RESET;
      cfg.mask[1]      <= stw_pkg::MASK1_RESET;
      cfg.mask[2]      <= stw_pkg::MASK2_RESET;
      cfg.mask[3]      <= stw_pkg::MASK3_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        stw_pkg::REG_LAG:   cfg.lag_distance <= cfg_data[7:0];
        stw_pkg::REG_LSH:   cfg.left_shift   <= cfg_data[4:0];
        stw_pkg::REG_RSH:   cfg.right_shift  <= cfg_data[4:0];
        stw_pkg::REG_MASK0: cfg.mask[0]      <= cfg_data;
        stw_pkg::REG_MASK1: cfg.mask[1]      <= cfg_data;
        stw_pkg::REG_MASK2: cfg.mask[2]      <= cfg_data;
        stw_pkg::REG_MASK3: cfg.mask[3]      <= cfg_data;
        default: ;
      endcase
    end
  end

  // control: read position, valid bits, output flag, seed and entry counters
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pos    <= '0;
      valid     <= '0;
      out_valid <= 1'b0;
      seed_idx  <= '0;
      ent       <= '0;
    end else begin
      // a new word replaces a taken one in the same cycle
      if (state == stw_pkg::ST_NEXT_OUT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      unique case (state)
        stw_pkg::ST_IDLE: begin
          seed_idx <= '0;
        end
        stw_pkg::ST_SEED: begin
          seed_idx <= seed_idx + 1'b1;
          if (seed_idx == stw_pkg::LAST_WORD) begin
            rd_pos <= stw_pkg::WORDS_END;
          end
        end
        stw_pkg::ST_REF_PREV: begin
          ent <= '0;
        end
        stw_pkg::ST_REF_WR: begin
          if (ent == stw_pkg::LAST_ENTRY) begin
            rd_pos <= '0;
          end else begin
            ent <= ent + 1'b1;
          end
        end
        stw_pkg::ST_NEXT_OUT: begin
          if (!out_valid || !out_stall) begin
            rd_pos <= rd_pos + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rd_a_en) begin
      va <= valid[rd_a_addr];
    end
    if (rd_b_en) begin
      vb <= valid[rd_b_addr];
    end
    if (accept_in) begin
      seed_first <= seed_value;
    end
    if (state == stw_pkg::ST_SEED) begin
      seed_word <= seed_cur;
      if (seed_idx[1:0] != 2'd3) begin
        seed_buf[seed_idx[1:0]] <= seed_cur;
      end
    end
    if (state == stw_pkg::ST_NEXT_RD) begin
      lane_sel <= rd_pos[1:0];
    end
    if (state == stw_pkg::ST_REF_PREV) begin
      prev <= data_a;
    end
    if (state == stw_pkg::ST_REF_WR) begin
      prev <= fresh;
    end
    if (state == stw_pkg::ST_NEXT_OUT && (!out_valid || !out_stall)) begin
      random_word <= data_a[lane_sel];
    end
  end

endmodule

FILE: verif/twister_word_checker.sv
// ----------------------------------------------------------------------------
// twister_word_checker: word predictor and checker for simd_twister_rng_128
// Watches the request, result and register channels. Keeps its own pool,
// read pointer and mixing settings, and compares every word taken from the
// block against the oldest predicted word.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module twister_word_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        command,
  input  logic [31:0] seed_value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] random_word,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          mismatches,
  output int          words_due_count
);
  import stw_pkg::*;

  logic [31:0] pool_words [POOL_WORDS];
  int          word_ptr;
  cfg_t        mix_cfg;
  logic [31:0] words_due [$];
  logic [31:0] want;

  function automatic void reset_model();
    foreach (pool_words[i]) pool_words[i] = '0;
    word_ptr             = 0;
    mix_cfg.lag_distance = LAG_RESET;
    mix_cfg.left_shift   = LSH_RESET;
    mix_cfg.right_shift  = RSH_RESET;
    mix_cfg.mask[0]      = MASK0_RESET;
    mix_cfg.mask[1]      = MASK1_RESET;
    mix_cfg.mask[2]      = MASK2_RESET;
    mix_cfg.mask[3]      = MASK3_RESET;
  endfunction

  function automatic void take_register(logic [2:0] idx, logic [31:0] data);
    case (idx)
      REG_LAG:   mix_cfg.lag_distance = data[7:0];
      REG_LSH:   mix_cfg.left_shift   = data[4:0];
      REG_RSH:   mix_cfg.right_shift  = data[4:0];
      REG_MASK0: mix_cfg.mask[0]      = data;
      REG_MASK1: mix_cfg.mask[1]      = data;
      REG_MASK2: mix_cfg.mask[2]      = data;
      REG_MASK3: mix_cfg.mask[3]      = data;
      default:   ;  // unmapped index, dropped
    endcase
  endfunction

  function automatic void seed_pool(logic [31:0] seed);
    logic [31:0] w;
    pool_words[0] = seed;
    for (int i = 1; i < POOL_WORDS; i++) begin
      w = pool_words[i-1];
      pool_words[i] = INIT_MULT * (w ^ (w >> 30)) + 32'(i);
    end
    word_ptr = POOL_WORDS;  // spent: next word refills first
  endfunction

  // in-place refill, entry by entry; lag entry may already be new
  function automatic void refill_pool();
    entry_t      prev;
    entry_t      fresh;
    int          lag;
    logic [31:0] rot;
    logic [31:0] sh;
    logic [31:0] mixed;
    for (int k = 0; k < LANES; k++)
      prev[k] = pool_words[(STATE_ENTRIES-1)*LANES + k];
    for (int i = 0; i < STATE_ENTRIES; i++) begin
      lag = (i + int'(mix_cfg.lag_distance)) % STATE_ENTRIES;
      for (int k = 0; k < LANES; k++) begin
        rot      = pool_words[i*LANES + ((k + 1) % LANES)];
        sh       = pool_words[lag*LANES + k] << mix_cfg.left_shift;
        mixed    = (prev[k] & mix_cfg.mask[k]) ^ (prev[k] >> mix_cfg.right_shift);
        fresh[k] = rot ^ sh ^ mixed;
      end
      for (int k = 0; k < LANES; k++)
        pool_words[i*LANES + k] = fresh[k];
      prev = fresh;
    end
  endfunction

  function automatic logic [31:0] next_word();
    logic [31:0] w;
    if (word_ptr >= POOL_WORDS) begin
      refill_pool();
      word_ptr = 0;
    end
    w = pool_words[word_ptr];
    word_ptr++;
    return w;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      reset_model();
      words_due.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready)
        take_register(cfg_index, cfg_data);
      if (out_valid && !out_stall) begin
        if (words_due.size() == 0) begin
          $error("random_word: expected none, actual %08h", random_word);
          mismatches++;
        end else begin
          want = words_due.pop_front();
          if (random_word !== want) begin
            $error("random_word: expected %08h, actual %08h", want, random_word);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (command == CMD_SEED)
          seed_pool(seed_value);
        else
          words_due.push_back(next_word());
      end
    end
    words_due_count = words_due.size();
  end

endmodule

FILE: verif/simd_twister_rng_128_tb.sv
// ----------------------------------------------------------------------------
// simd_twister_rng_128_tb: top-level testbench for the SIMD twister generator
// Drives next and seed requests and register writes, stalls the result side,
// and leaves prediction and comparison to twister_word_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module simd_twister_rng_128_tb;
  import stw_pkg::*;

  localparam int          CYCLE_LIMIT  = 5_000_000;
  // a seed shows no word while it runs, so wait past its end
  localparam int          QUIET_CYCLES = 700;
  // outlasts a seed plus a refill, so words back up behind the hold
  localparam int          HOLD_CYCLES  = 1500;
  // a few more than a full pool, so the read pointer wraps and refills
  localparam int          ZERO_RUN     = POOL_WORDS + 4;
  localparam int          LONG_RUN     = 24;
  localparam logic [2:0]  REG_UNUSED   = 3'd7;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic        command    = CMD_NEXT;
  logic [31:0] seed_value = '0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [31:0] random_word;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index  = REG_LAG;
  logic [31:0] cfg_data   = '0;

  int mismatches;
  int words_due_count;
  int cycle_count   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // long receiver hold-off: requested here, counted down in the stall process
  int hold_requests = 0;
  int hold_seen     = 0;
  int hold_left     = 0;

  always #5 clk = ~clk;

  simd_twister_rng_128 dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .seed_value  (seed_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .random_word (random_word),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  twister_word_checker word_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .command         (command),
    .seed_value      (seed_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .random_word     (random_word),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .words_due_count (words_due_count)
  );

  // Result side: a pending hold-off request wins, then its countdown,
  // otherwise a random stall at the current idle rate.
  always @(negedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offer one request; entered and left at a falling edge. Valid stays high
  // on exit so back-to-back requests never drop it within one step.
  task automatic send_request(input logic cmd, input logic [31:0] seed);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    seed_value <= seed;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly next requests; seeds are rare and lean on the extreme values.
  task automatic random_requests(input int count);
    int          pick;
    logic [31:0] seed;
    repeat (count) begin
      pick = $urandom_range(99, 0);
      case ($urandom_range(7, 0))
        0:       seed = '0;
        1:       seed = '1;
        default: seed = $urandom;
      endcase
      send_request((pick < 6) ? CMD_SEED : CMD_NEXT, seed);
    end
  endtask

  // Drop valid, let every predicted word drain, then cover a seed in flight.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (words_due_count != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  // One register write; leaves cfg_valid high for a following write.
  task automatic cfg_put(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Full register set. Upper data bits are junk: the block must drop them.
  task automatic apply_settings(input logic [7:0] lag, input logic [4:0] lsh,
                                input logic [4:0] rsh, input logic [31:0] m0,
                                input logic [31:0] m1, input logic [31:0] m2,
                                input logic [31:0] m3, input logic poke_unused);
    if (poke_unused)
      cfg_put(REG_UNUSED, $urandom);
    cfg_put(REG_LAG,   {24'($urandom), lag});
    cfg_put(REG_LSH,   {27'($urandom), lsh});
    cfg_put(REG_RSH,   {27'($urandom), rsh});
    cfg_put(REG_MASK0, m0);
    cfg_put(REG_MASK1, m1);
    cfg_put(REG_MASK2, m2);
    cfg_put(REG_MASK3, m3);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Phase 1, reset settings; sender idles little, receiver about half.
    send_idle_pct = 6;
    recv_idle_pct = 49;
    // no seed yet: zero pool gives zeros, and its refill stays zero
    repeat (ZERO_RUN) send_request(CMD_NEXT, $urandom);
    // seeds at the extremes, back-to-back seeds, a seed mid-pool
    send_request(CMD_SEED, 32'h0000_0000);
    send_request(CMD_NEXT, 32'hffff_ffff);
    send_request(CMD_NEXT, 32'h0000_0000);
    send_request(CMD_SEED, 32'hffff_ffff);
    send_request(CMD_SEED, 32'h0000_0001);
    repeat (3) send_request(CMD_NEXT, $urandom);
    send_request(CMD_SEED, 32'h8000_0000);
    send_request(CMD_NEXT, $urandom);
    send_request(CMD_SEED, 32'h7fff_ffff);
    repeat (2) send_request(CMD_NEXT, $urandom);
    send_request(CMD_SEED, 32'hffff_ffff);
    send_request(CMD_NEXT, $urandom);
    wait_quiet();

    // Phase 2: everything at its low end; lag 0 reads the entry itself.
    apply_settings(8'd0, 5'd0, 5'd0, '0, '0, '0, '0, 1'b0);
    random_requests(150);
    wait_quiet();

    // Phase 3: high end plus a write to an unmapped index; roles swap.
    // One seed, its refill, and a short run through the fresh pool.
    send_idle_pct = 49;
    recv_idle_pct = 6;
    apply_settings(8'd155, 5'd31, 5'd31, '1, '1, '1, '1, 1'b1);
    send_request(CMD_SEED, $urandom);
    repeat (LONG_RUN) send_request(CMD_NEXT, $urandom);
    wait_quiet();

    // Phase 4: lag equal to the entry count wraps onto the entry itself.
    apply_settings(8'd156, 5'($urandom), 5'($urandom),
                   $urandom, $urandom, $urandom, $urandom, 1'b0);
    random_requests(150);
    wait_quiet();

    // Phase 5: widest lag, no idling; receiver holds off long enough
    // that the block backs up and stalls requests.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_settings(8'd255, 5'd1, 5'd1, $urandom, $urandom, $urandom, $urandom, 1'b0);
    send_request(CMD_SEED, $urandom);
    hold_requests <= hold_requests + 1;
    random_requests(100);
    wait_quiet();

    // Phase 6: lag of one, masks back to their reset values.
    apply_settings(8'd1, 5'($urandom), 5'($urandom),
                   MASK0_RESET, MASK1_RESET, MASK2_RESET, MASK3_RESET, 1'b0);
    random_requests(100);
    wait_quiet();

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
